// ===== hw/rtl/nttg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nttg_pkg
// Shared constants and modular arithmetic helpers for the twiddle generator.
// ----------------------------------------------------------------------------
package nttg_pkg;

    localparam int unsigned VAL_W      = 23;
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned INDEX_BITS = 8;
    localparam logic [VAL_W-1:0] MODULUS   = 23'd8380417;
    localparam logic [VAL_W-1:0] ROOT_INIT = 23'd1753;
    localparam int unsigned PROD_W = 2 * VAL_W;
    // Register stages in one modular multiplier
    localparam int unsigned MUL_LAT = 3;

    // Reduce a value below 2^23 into [0, MODULUS).
    function automatic logic [VAL_W-1:0] fold(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] r;
        r = (v >= MODULUS) ? (v - MODULUS) : v;
        return r;
    endfunction

    // Reverse the low INDEX_BITS bits of an index.
    function automatic logic [INDEX_BITS-1:0] bit_rev(input logic [IDX_W-1:0] v);
        logic [INDEX_BITS-1:0] r;
        for (int i = 0; i < INDEX_BITS; i++) begin
            r[i] = v[INDEX_BITS-1-i];
        end
        return r;
    endfunction

    typedef struct packed {
        logic [VAL_W-1:0]      acc;
        logic [VAL_W-1:0]      base;
        logic [INDEX_BITS-1:0] expo;
        logic                  last;
    } step_t;

endpackage

// ===== hw/rtl/nttg_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nttg_mulmod
// Pipelined a*b mod MODULUS: multiply, then reduce over two stages.
// Registers prod_reg, then q_reg with rem_reg, then p; advances when en is high.
// ----------------------------------------------------------------------------
module nttg_mulmod (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [nttg_pkg::VAL_W-1:0] a,
    input  logic [nttg_pkg::VAL_W-1:0] b,
    output logic [nttg_pkg::VAL_W-1:0] p
);
    import nttg_pkg::*;

    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [VAL_W-1:0]   q_reg;
    logic [24:0]        rem_reg;
    logic [VAL_W-1:0]   r_next;
    logic [PROD_W-1:0]  qm;
    logic [24:0]        r25;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    // Quotient estimate: q = ((x >> 22) * floor(2^46 / M)) >> 24,
    // at most two below the true quotient, fixed by the folds below.
    localparam logic [VAL_W:0] RECIP = (VAL_W+1)'((64'd1 << PROD_W) / 64'(MODULUS));
    logic [2*VAL_W+1:0] qmul;
    assign qmul = (2*VAL_W+2)'(prod_reg[PROD_W-1:VAL_W-1]) * (2*VAL_W+2)'(RECIP);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            q_reg    <= qmul[2*VAL_W:VAL_W+1];
            rem_reg  <= prod_reg[24:0];
            p        <= r_next;
        end
    end

    // Remainder is below 3*M, which fits in 25 bits.
    assign qm  = PROD_W'(q_reg) * PROD_W'(MODULUS);
    assign r25 = rem_reg - qm[24:0];
    always_comb begin
        logic [24:0] t;
        t = r25;
        if (t >= 25'(MODULUS)) t = t - 25'(MODULUS);
        if (t >= 25'(MODULUS)) t = t - 25'(MODULUS);
        r_next = t[VAL_W-1:0];
    end
endmodule

// ===== hw/rtl/nttg_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nttg_step
// One square-and-multiply round: acc*=base if exponent bit set; base*=base.
// ----------------------------------------------------------------------------
module nttg_step (
    input  logic                 aclk,
    input  logic                 en,
    input  nttg_pkg::step_t      din,
    output nttg_pkg::step_t      dout
);
    import nttg_pkg::*;

    logic [VAL_W-1:0] acc_prod;
    logic [VAL_W-1:0] sq_prod;
    logic [MUL_LAT-1:0]    use_reg;
    logic [INDEX_BITS-1:0] expo_reg [MUL_LAT];
    logic [MUL_LAT-1:0]    last_reg;
    logic [VAL_W-1:0] acc_reg [MUL_LAT];

    nttg_mulmod u_mul (.aclk(aclk), .en(en), .a(din.acc),  .b(din.base), .p(acc_prod));
    nttg_mulmod u_sq  (.aclk(aclk), .en(en), .a(din.base), .b(din.base), .p(sq_prod));

    always_ff @(posedge aclk) begin
        if (en) begin
            use_reg[0]  <= din.expo[0];
            expo_reg[0] <= din.expo >> 1;
            last_reg[0] <= din.last;
            acc_reg[0]  <= din.acc;
            for (int i = 1; i < MUL_LAT; i++) begin
                use_reg[i]  <= use_reg[i-1];
                expo_reg[i] <= expo_reg[i-1];
                last_reg[i] <= last_reg[i-1];
                acc_reg[i]  <= acc_reg[i-1];
            end
        end
    end

    assign dout.acc  = use_reg[MUL_LAT-1] ? acc_prod : acc_reg[MUL_LAT-1];
    assign dout.base = sq_prod;
    assign dout.expo = expo_reg[MUL_LAT-1];
    assign dout.last = last_reg[MUL_LAT-1];
endmodule

// ===== hw/rtl/ntt_twiddle_table_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_twiddle_table_generator
// Twiddle factors root^bitrev(index) mod 8380417, one item per cycle.
//
//   channel  | dir | tdata              | tlast
//   s_axis   | in  | [7:0] index        | last_request
//   m_axis   | out | [22:0] twiddle     | last_entry
//   cfg      | in  | [22:0] root        | -
//
// Throughput one item per cycle unless the output stalls. Items pass an
// input register, then eight square-and-multiply rounds, each a
// three-stage modular multiplier pair. The whole pipe advances together
// when the output register is empty or taken, so a stall holds every
// stage. Reset clears the valid bits and sets root to 1753.
// ----------------------------------------------------------------------------
module ntt_twiddle_table_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [22:0] cfg_wr_data,   // root
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] index
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [22:0] twiddle, [23] zero pad
    output logic        m_axis_tlast
);
    import nttg_pkg::*;

    localparam int ROUNDS = INDEX_BITS;
    localparam int DEPTH  = 1 + ROUNDS * MUL_LAT;

    logic [VAL_W-1:0] root_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    step_t            in_reg;
    step_t            chain [ROUNDS+1];

    // Advance when the output slot is free or being taken.
    assign adv           = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= ROOT_INIT;
            vld_reg  <= '0;
        end else begin
            if (cfg_wr_en) root_reg <= cfg_wr_data;
            if (adv) vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg.acc  <= VAL_W'(1);
            in_reg.base <= fold(root_reg);
            in_reg.expo <= bit_rev(s_axis_tdata);
            in_reg.last <= s_axis_tlast;
        end
    end

    assign chain[0] = in_reg;
    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        nttg_step u_step (.aclk(aclk), .en(adv), .din(chain[g]), .dout(chain[g+1]));
    end

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = {1'b0, chain[ROUNDS].acc};
    assign m_axis_tlast  = chain[ROUNDS].last;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipe blocked with empty output");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[22:0] < MODULUS)
        else $error("twiddle out of range");
endmodule

// ===== tb/ntt_twiddle_table_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_twiddle_table_generator_tb
// Drives table indices through the twiddle generator under several root
// settings and idle patterns, and checks each twiddle factor and last flag
// against a power computed here with plain modular arithmetic.
// ----------------------------------------------------------------------------
module ntt_twiddle_table_generator_tb;
    import nttg_pkg::*;

    localparam int unsigned PIPE_DEPTH = 25;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [22:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] index
    logic        s_axis_tlast;   // last_request
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [22:0] twiddle, [23] zero pad
    logic        m_axis_tlast;   // last_entry

    typedef struct packed {
        logic [VAL_W-1:0] twiddle;
        logic             last;
    } twiddle_t;

    twiddle_t    pending_twiddles[$];
    logic [22:0] cur_root;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          results_seen;
    int          items_sent;

    ntt_twiddle_table_generator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("ntt_twiddle_table_generator test failed");
        $finish;
    end

    // root^bitrev(index) mod MODULUS, computed with 64-bit integers
    function automatic logic [VAL_W-1:0] twiddle_of(input logic [22:0] base_in,
                                                    input logic [7:0] index);
        longint unsigned m;
        longint unsigned acc;
        longint unsigned b;
        int unsigned     e;
        m   = 64'd8380417;
        acc = 1;
        b   = base_in % m;
        e   = 0;
        for (int i = 0; i < 8; i++) begin
            e = (e << 1) | index[i];
        end
        while (e != 0) begin
            if (e & 1) acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc[VAL_W-1:0];
    endfunction

    task automatic send_index(input logic [7:0] index, input logic last);
        twiddle_t exp_t;
        // drop valid only while idling, so back-to-back items keep it high
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= index;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        exp_t.twiddle = twiddle_of(cur_root, index);
        exp_t.last    = last;
        pending_twiddles.push_back(exp_t);
        items_sent++;
    endtask

    // wait for the pipe to drain, then write root while idle
    task automatic write_root(input logic [22:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_twiddles.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 5) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_root = value;
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        twiddle_t exp_t;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_twiddles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: twiddle %0d last %0b",
                             m_axis_tdata[22:0], m_axis_tlast);
            end else begin
                exp_t = pending_twiddles.pop_front();
                if (m_axis_tdata[22:0] !== exp_t.twiddle || m_axis_tlast !== exp_t.last
                        || m_axis_tdata[23] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b, got %0d/%0b (pad %b)",
                                 exp_t.twiddle, exp_t.last, m_axis_tdata[22:0],
                                 m_axis_tlast, m_axis_tdata[23]);
                end
            end
        end
    end

    task automatic test_directed();
        send_index(8'd0, 1'b0);
        send_index(8'd255, 1'b1);
        send_index(8'd1, 1'b0);
        send_index(8'd128, 1'b0);
        send_index(8'h55, 1'b1);
        send_index(8'hAA, 1'b0);
        write_root(23'd0);
        send_index(8'd0, 1'b0);
        send_index(8'd1, 1'b1);
        send_index(8'd255, 1'b0);
        write_root(23'h7FFFFF);   // above the modulus, reduced first
        send_index(8'd0, 1'b0);
        send_index(8'd3, 1'b0);
        send_index(8'd255, 1'b1);
        write_root(23'd8380416);
        send_index(8'd128, 1'b0);
        send_index(8'd127, 1'b1);
        write_root(23'd8380417);
        send_index(8'd64, 1'b1);
        send_index(8'd0, 1'b0);
    endtask

    task automatic test_full_table(input logic [22:0] value);
        write_root(value);
        for (int i = 0; i < 256; i++) begin
            send_index(i[7:0], i == 255);
        end
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        write_root(23'($urandom_range(8380416)));
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            send_index(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        results_seen   = 0;
        items_sent     = 0;
        cur_root       = ROOT_INIT;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_table(23'd1753);
        test_random(220, 0, 0);
        test_random(220, 78, 0);
        test_random(220, 0, 78);
        test_random(220, 35, 35);
        test_random(100, 0, 0);

        s_axis_tvalid <= 1'b0;
        while (pending_twiddles.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 10) @(posedge aclk);
        $display("Sent %0d indices (directed, full table, random) over several roots",
                 items_sent);
        $display("and idle patterns; checked %0d results, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && pending_twiddles.size() == 0) begin
            $display("ntt_twiddle_table_generator test passed");
        end else begin
            $display("ntt_twiddle_table_generator test failed");
        end
        $finish;
    end

endmodule
